// ----- sv/lrupr_pkg.sv -----
// Package with the types, codes and sizes shared by the LRU page replacement list.
`timescale 1ns / 1ps

package lrupr_pkg;

    localparam int NUM_PAGES = 16;
    localparam int PAGE_W    = 4;
    localparam int IDX_W     = $clog2(NUM_PAGES);
    localparam int CNT_W     = $clog2(NUM_PAGES + 1);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_EVICT  = 2'd1;
    localparam logic [1:0] REQ_ACCESS = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DUP   = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [PAGE_W-1:0] page_id;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] victim_page;
        logic              victim_valid;
        logic [1:0]        status;
    } rsp_t;

    // Move-to-front command for the order list.
    typedef struct packed {
        logic              shift_en;
        logic [IDX_W-1:0]  shift_pos;
        logic [PAGE_W-1:0] new_page;
    } list_ctrl_t;

endpackage

// ----- sv/lrupr_list.sv -----
// Recency order list: a register file with a move-to-front shifter and one read port.
`timescale 1ns / 1ps

module lrupr_list (
    input  logic                        clk,
    input  lrupr_pkg::list_ctrl_t       ctrl,
    input  logic [lrupr_pkg::IDX_W-1:0] rd_addr,
    output logic [lrupr_pkg::PAGE_W-1:0] rd_page
);
    import lrupr_pkg::*;

    logic [PAGE_W-1:0] order_reg  [NUM_PAGES];
    logic [PAGE_W-1:0] order_next [NUM_PAGES];

    // Entries from the front up to shift_pos move back by one, and the
    // new page lands at the front. Entries behind shift_pos stay put.
    always_comb
    begin
        order_next = order_reg;
        if (ctrl.shift_en)
        begin
            order_next[0] = ctrl.new_page;
            for (int j = 1; j < NUM_PAGES; j++)
            begin
                if (IDX_W'(j) <= ctrl.shift_pos)
                begin
                    order_next[j] = order_reg[j-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg <= order_next;
    end

    assign rd_page = order_reg[rd_addr];

endmodule

// ----- sv/lru_page_replacement_list.sv -----
// Top level of the LRU page replacement list with accessed marks.
`timescale 1ns / 1ps

// Each request word yields exactly one response word. Insert, evict and
// access are taken one per cycle. A tick on a non-empty list starts a walk
// that visits one list entry per cycle through the single move-to-front
// shifter; no request is taken during the walk. Its response word is
// issued at once, since a tick always reports ok. A request is also held
// off while an earlier response word waits and is stalled.
module lru_page_replacement_list (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  lrupr_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output lrupr_pkg::rsp_t rsp
);
    import lrupr_pkg::*;

    typedef enum logic {S_IDLE, S_WALK} state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_PAGES-1:0] resident_reg, resident_next;
    logic [NUM_PAGES-1:0] accessed_reg, accessed_next;
    logic [IDX_W-1:0]     walk_reg, walk_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    list_ctrl_t           list_ctrl;
    logic [IDX_W-1:0]     rd_addr;
    logic [PAGE_W-1:0]    rd_page;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     pg_idx;
    logic                 pg_in_range;
    logic                 accept;
    logic                 walk_last;

    lrupr_list u_list (
        .clk     (clk),
        .ctrl    (list_ctrl),
        .rd_addr (rd_addr),
        .rd_page (rd_page)
    );

    assign req_stall   = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept      = req_valid && !req_stall;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;

    assign pg_idx      = IDX_W'(req.page_id);
    assign pg_in_range = (32'(req.page_id) < NUM_PAGES);
    assign rd_idx      = IDX_W'(rd_page);
    assign walk_last   = ((CNT_W'(walk_reg) + CNT_W'(1)) == count_reg);

    // The walk reads the entry under the walk pointer; otherwise the read
    // port sits on the back of the list for an evict.
    assign rd_addr = (state_reg == S_WALK) ? walk_reg : IDX_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        resident_next  = resident_reg;
        accessed_next  = accessed_reg;
        walk_next      = walk_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        list_ctrl      = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_next        = '0;
                    rsp_next.status = STATUS_OK;
                    case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (pg_in_range)
                            begin
                                if (resident_reg[pg_idx])
                                begin
                                    rsp_next.status = STATUS_DUP;
                                end
                                else if (count_reg < CNT_W'(NUM_PAGES))
                                begin
                                    list_ctrl.shift_en  = 1'b1;
                                    list_ctrl.shift_pos = IDX_W'(count_reg);
                                    list_ctrl.new_page  = req.page_id;
                                    count_next          = count_reg + CNT_W'(1);
                                    resident_next[pg_idx] = 1'b1;
                                    accessed_next[pg_idx] = 1'b0;
                                end
                            end
                        end
                        REQ_EVICT:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                rsp_next.victim_page  = rd_page;
                                rsp_next.victim_valid = 1'b1;
                                count_next            = count_reg - CNT_W'(1);
                                resident_next[rd_idx] = 1'b0;
                                accessed_next[rd_idx] = 1'b0;
                            end
                        end
                        REQ_ACCESS:
                        begin
                            if (pg_in_range && resident_reg[pg_idx])
                            begin
                                accessed_next[pg_idx] = 1'b1;
                            end
                        end
                        REQ_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_WALK;
                                walk_next  = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // Moving a marked page to the front leaves the next entry in
                // place, so the pointer always steps by one.
                if (accessed_reg[rd_idx])
                begin
                    list_ctrl.shift_en    = 1'b1;
                    list_ctrl.shift_pos   = walk_reg;
                    list_ctrl.new_page    = rd_page;
                    accessed_next[rd_idx] = 1'b0;
                end
                if (walk_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            resident_reg  <= '0;
            accessed_reg  <= '0;
            walk_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            resident_reg  <= resident_next;
            accessed_reg  <= accessed_next;
            walk_reg      <= walk_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // The list length always matches the number of resident pages.
    a_count_matches_resident: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(resident_reg) == 32'(count_reg))
        else $error("list length differs from resident page count");

    // A walk never runs past the end of the list.
    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (CNT_W'(walk_reg) < count_reg))
        else $error("walk pointer beyond list end");

    // The list length does not change while a walk is running.
    a_walk_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |=> $stable(count_reg))
        else $error("list length changed during walk");

    // A returned victim always comes with an ok status.
    a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.victim_valid) |-> (rsp_reg.status == STATUS_OK))
        else $error("victim reported with non-ok status");

    // An evict that finds pages shortens the list by one.
    a_evict_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == REQ_EVICT) && (count_reg != '0))
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("evict did not shorten the list");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the LRU page replacement list.
`timescale 1ns / 1ps

module testbench;
    import lrupr_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_WORDS = 1300;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    typedef struct packed {
        req_t word;
        logic typed;
        rsp_t rsp;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;

    // Rows with typed set carry a result that is obvious from the list contents.
    localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
        '{'{REQ_EVICT,  4'hF}, 1'b1, '{4'd0, 1'b0, STATUS_EMPTY}},
        '{'{REQ_TICK,   4'hA}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_ACCESS, 4'd5}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_INSERT, 4'd0}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_INSERT, 4'hF}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_INSERT, 4'd0}, 1'b1, '{4'd0, 1'b0, STATUS_DUP}},
        '{'{REQ_INSERT, 4'd10}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_INSERT, 4'd5}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_ACCESS, 4'd0}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_ACCESS, 4'd10}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_ACCESS, 4'd3}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_TICK,   4'd0}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_EVICT,  4'd0}, 1'b0, '0},
        '{'{REQ_EVICT,  4'hF}, 1'b0, '0},
        '{'{REQ_ACCESS, 4'd5}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_INSERT, 4'hF}, 1'b0, '0},
        '{'{REQ_EVICT,  4'd7}, 1'b0, '0},
        '{'{REQ_TICK,   4'hF}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_EVICT,  4'd0}, 1'b0, '0},
        '{'{REQ_EVICT,  4'd0}, 1'b0, '0},
        '{'{REQ_EVICT,  4'd0}, 1'b1, '{4'd0, 1'b0, STATUS_EMPTY}},
        '{'{REQ_INSERT, 4'd3}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_ACCESS, 4'd3}, 1'b1, '{4'd0, 1'b0, STATUS_OK}},
        '{'{REQ_EVICT,  4'd0}, 1'b1, '{4'd3, 1'b1, STATUS_OK}},
        '{'{REQ_INSERT, 4'd3}, 1'b1, '{4'd0, 1'b0, STATUS_OK}}
    };

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    req_t req       = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    // Predicted block state: index 0 of the order is the most recent page.
    logic [PAGE_W-1:0]    page_order[$];
    logic [NUM_PAGES-1:0] page_resident = '0;
    logic [NUM_PAGES-1:0] page_marked   = '0;

    rsp_t expected_rsp_q[$];
    rsp_t received_rsp_q[$];
    rsp_t want_rsp;
    rsp_t got_rsp;

    int accepted_words = 0;
    int received_words = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int insert_count   = 0;
    int dup_count      = 0;
    int victim_count   = 0;
    int empty_count    = 0;
    int mark_count     = 0;
    int tick_count     = 0;
    int full_count     = 0;

    int stall_mode      = STALL_NONE;
    int stall_phase_left = 0;

    lru_page_replacement_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Updates the predicted list for one request and returns its response word.
    function automatic rsp_t apply_request(req_t w);
        rsp_t              r;
        logic [PAGE_W-1:0] walked[$];
        logic [PAGE_W-1:0] victim;
        r = '0;
        r.status = STATUS_OK;
        case (w.req_type)
            REQ_INSERT:
            begin
                if (int'(w.page_id) < NUM_PAGES)
                begin
                    if (page_resident[w.page_id])
                    begin
                        r.status = STATUS_DUP;
                        dup_count++;
                    end
                    else if (page_order.size() < NUM_PAGES)
                    begin
                        page_order.push_front(w.page_id);
                        page_resident[w.page_id] = 1'b1;
                        page_marked[w.page_id]   = 1'b0;
                        insert_count++;
                        if (page_order.size() == NUM_PAGES)
                            full_count++;
                    end
                end
            end
            REQ_EVICT:
            begin
                if (page_order.size() == 0)
                begin
                    r.status = STATUS_EMPTY;
                    empty_count++;
                end
                else
                begin
                    victim = page_order.pop_back();
                    page_resident[victim] = 1'b0;
                    page_marked[victim]   = 1'b0;
                    r.victim_page  = victim;
                    r.victim_valid = 1'b1;
                    victim_count++;
                end
            end
            REQ_ACCESS:
            begin
                if (int'(w.page_id) < NUM_PAGES && page_resident[w.page_id])
                begin
                    page_marked[w.page_id] = 1'b1;
                    mark_count++;
                end
            end
            default:
            begin
                // Marked pages come out in reverse walk order, then the rest in order.
                for (int i = page_order.size() - 1; i >= 0; i--)
                    if (page_marked[page_order[i]])
                        walked.push_back(page_order[i]);
                for (int i = 0; i < page_order.size(); i++)
                    if (!page_marked[page_order[i]])
                        walked.push_back(page_order[i]);
                page_order  = walked;
                page_marked = '0;
                tick_count++;
            end
        endcase
        return r;
    endfunction

    // Draws a random request, steered toward filling or draining the list.
    function automatic req_t pick_request(bit shrinking);
        req_t              w;
        int                roll;
        logic [PAGE_W-1:0] free_pages[$];
        roll = $urandom_range(0, 99);
        w.page_id = PAGE_W'($urandom_range(0, 2**PAGE_W - 1));
        if (roll < (shrinking ? 15 : 45))
        begin
            w.req_type = REQ_INSERT;
            for (int p = 0; p < NUM_PAGES; p++)
                if (!page_resident[p])
                    free_pages.push_back(PAGE_W'(p));
            if (free_pages.size() > 0 && $urandom_range(0, 99) < 85)
                w.page_id = free_pages[$urandom_range(0, free_pages.size() - 1)];
        end
        else if (roll < (shrinking ? 55 : 57))
            w.req_type = REQ_EVICT;
        else if (roll < 88)
        begin
            w.req_type = REQ_ACCESS;
            if (page_order.size() > 0 && $urandom_range(0, 99) < 80)
                w.page_id = page_order[$urandom_range(0, page_order.size() - 1)];
        end
        else
            w.req_type = REQ_TICK;
        return w;
    endfunction

    task automatic send_request(input req_t w, input logic typed, input rsp_t typed_rsp);
        rsp_t predicted;
        req_valid <= 1'b1;
        req       <= w;
        do
            @(posedge clk);
        while (req_stall);
        predicted = apply_request(w);
        expected_rsp_q.push_back(typed ? typed_rsp : predicted);
        accepted_words++;
    endtask

    task automatic idle_cycles(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        if (received_words < accepted_words)
        begin
            req_valid <= 1'b0;
            while (received_words < accepted_words)
                @(posedge clk);
        end
    endtask

    // Response stalls follow their own pattern, changing mode now and then.
    always @(posedge clk)
    begin
        if (stall_phase_left == 0)
        begin
            stall_mode       <= $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_phase_left <= $urandom_range(20, 300);
            rsp_stall        <= 1'b0;
        end
        else
        begin
            stall_phase_left <= stall_phase_left - 1;
            case (stall_mode)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                default:     rsp_stall <= stall_phase_left[3];
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            received_rsp_q.push_back(rsp);
    end

    // Comparison runs on the falling edge, after both queues are settled.
    always @(negedge clk)
    begin
        while (received_rsp_q.size() > 0)
        begin
            got_rsp = received_rsp_q.pop_front();
            if (expected_rsp_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected word: page %0d valid %0b status %0d",
                             got_rsp.victim_page, got_rsp.victim_valid, got_rsp.status);
            end
            else
            begin
                want_rsp = expected_rsp_q.pop_front();
                if (got_rsp.victim_page !== want_rsp.victim_page
                    || got_rsp.victim_valid !== want_rsp.victim_valid
                    || got_rsp.status !== want_rsp.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"mismatch on word %0d: expected page %0d valid %0b ",
                                  "status %0d, got page %0d valid %0b status %0d"},
                                 received_words, want_rsp.victim_page,
                                 want_rsp.victim_valid, want_rsp.status,
                                 got_rsp.victim_page, got_rsp.victim_valid,
                                 got_rsp.status);
                end
            end
            received_words++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d words answered",
                     cycle_count, received_words, accepted_words);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int  burst_left;
        bit  shrinking;
        bit  steady;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_request(DIRECTED[r].word, DIRECTED[r].typed, DIRECTED[r].rsp);
            if (r % 4 == 3)
                idle_cycles($urandom_range(1, 3));
        end
        wait_drained();

        shrinking  = 1'b0;
        steady     = 1'b0;
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == RANDOM_WORDS / 2)
                wait_drained();
            if (page_order.size() == NUM_PAGES)
                shrinking = 1'b1;
            else if (page_order.size() == 0)
                shrinking = 1'b0;
            else if ($urandom_range(0, 49) == 0)
                shrinking = !shrinking;
            send_request(pick_request(shrinking), 1'b0, '0);
            burst_left--;
            if (burst_left == 0)
            begin
                if (!steady)
                    idle_cycles($urandom_range(1, 10));
                burst_left = $urandom_range(1, 24);
                steady     = ($urandom_range(0, 4) == 0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rsp_q.size() != 0)
        begin
            $display("%0d expected words never arrived", expected_rsp_q.size());
            mismatch_count += expected_rsp_q.size();
        end

        $display("%0d words in %0d cycles: %0d inserts, %0d duplicates, %0d marks, %0d ticks",
                 accepted_words, cycle_count, insert_count, dup_count, mark_count, tick_count);
        $display("%0d victims, %0d evicts on an empty list, list full %0d times, %0d mismatches",
                 victim_count, empty_count, full_count, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- lru_page_replacement_list.f -----
sv/lrupr_pkg.sv
sv/lrupr_list.sv
sv/lru_page_replacement_list.sv
verif/testbench.sv
